[src/deq_pkg.sv]
// Package for the double-ended queue: request, status and cell control types.
// No dependencies; used by deq_cell, deq_chain and double_ended_queue_core.
`default_nettype none

package deq_pkg;

    // Width of one stored word
    localparam int DATA_W  = 32;
    // Width of the reported item count
    localparam int COUNT_W = 7;

    // Request codes
    typedef enum logic [1:0] {
        REQ_ADD_BACK     = 2'd0,
        REQ_ADD_FRONT    = 2'd1,
        REQ_REMOVE_BACK  = 2'd2,
        REQ_REMOVE_FRONT = 2'd3
    } t_req;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What one cell loads on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TAKE_LEFT  = 2'd1,
        CELL_TAKE_RIGHT = 2'd2,
        CELL_TAKE_VALUE = 2'd3
    } t_cell_op;

    // Control for one chain of cells
    typedef struct packed {
        logic ins_head;  // shift toward the tail, new word enters at cell 0
        logic del_head;  // shift toward cell 0, head word leaves
        logic wr_tail;   // write new word at the cell just past the tail
    } t_chain_ctrl;

endpackage

`default_nettype wire

[src/deq_cell.sv]
// One storage cell of a deque chain: holds a word, takes it from a neighbor
// or from the request. Depends on deq_pkg.
`default_nettype none

module deq_cell (
    input  wire logic                                i_clk,
    input  wire deq_pkg::t_cell_op                   i_op,
    input  wire logic signed [deq_pkg::DATA_W-1:0]   i_left,
    input  wire logic signed [deq_pkg::DATA_W-1:0]   i_right,
    input  wire logic signed [deq_pkg::DATA_W-1:0]   i_value,
    output logic signed      [deq_pkg::DATA_W-1:0]   o_data
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    // Next word select
    always_comb begin
        case (i_op)
            CELL_HOLD:       n_data = r_data;
            CELL_TAKE_LEFT:  n_data = i_left;
            CELL_TAKE_RIGHT: n_data = i_right;
            CELL_TAKE_VALUE: n_data = i_value;
            default:         n_data = r_data;
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[src/deq_chain.sv]
// Row of deq_cell instances holding the deque in order from cell 0 (head).
// Depends on deq_pkg and deq_cell.
`default_nettype none

module deq_chain #(
    parameter int CAPACITY = 64,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                                i_clk,
    input  wire deq_pkg::t_chain_ctrl                i_ctrl,
    input  wire logic [CW-1:0]                       i_count,
    input  wire logic signed [deq_pkg::DATA_W-1:0]   i_value,
    output logic signed      [deq_pkg::DATA_W-1:0]   o_head
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_cell_op                 op;
            logic signed [DATA_W-1:0] left_in;
            logic signed [DATA_W-1:0] right_in;

            // Neighbor words; the ends see the new word or themselves
            if (g == 0) begin : g_first
                assign left_in = i_value;
            end else begin : g_mid_l
                assign left_in = cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_in = cell_data[g];
            end else begin : g_mid_r
                assign right_in = cell_data[g+1];
            end

            // Per-cell decode of the chain command
            always_comb begin
                if (i_ctrl.ins_head) begin
                    op = CELL_TAKE_LEFT;
                end else if (i_ctrl.del_head) begin
                    op = CELL_TAKE_RIGHT;
                end else if (i_ctrl.wr_tail && (i_count == CW'(g))) begin
                    op = CELL_TAKE_VALUE;
                end else begin
                    op = CELL_HOLD;
                end
            end

            deq_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (op),
                .i_left  (left_in),
                .i_right (right_in),
                .i_value (i_value),
                .o_data  (cell_data[g])
            );
        end
    endgenerate

    assign o_head = cell_data[0];

endmodule

`default_nettype wire

[src/double_ended_queue_core.sv]
// Double-ended queue built from two cell chains: one ordered front to back,
// one back to front, so both ends are always read at cell 0.
// Result word is registered on the clock edge that accepts the request.
// Throughput: one request per cycle; a waiting result holds the input off.
// Reset: count zero, output empty; stored words are undefined until written.
// Depends on deq_pkg and deq_chain.
`default_nettype none

module double_ended_queue_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [1:0]                          i_req_type,
    input  wire logic signed [deq_pkg::DATA_W-1:0]   i_value,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [deq_pkg::DATA_W-1:0]        o_removed_value,
    output logic [1:0]                               o_status,
    output logic [deq_pkg::COUNT_W-1:0]              o_item_count
);
    import deq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_removed;
    logic signed [DATA_W-1:0] n_removed;
    t_status                  r_status;
    t_status                  n_status;
    logic [COUNT_W-1:0]       r_item_count;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    t_chain_ctrl              ctrl_fwd;   // head is the front
    t_chain_ctrl              ctrl_rev;   // head is the back
    logic signed [DATA_W-1:0] front_word;
    logic signed [DATA_W-1:0] back_word;

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);

    // Request decode: chain commands, result word and next count
    always_comb begin
        ctrl_fwd  = '0;
        ctrl_rev  = '0;
        n_status  = ST_OK;
        n_removed = '0;
        n_count   = r_count;
        if (accept) begin
            case (t_req'(i_req_type))
                REQ_ADD_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctrl_fwd.wr_tail  = 1'b1;
                        ctrl_rev.ins_head = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                REQ_ADD_FRONT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctrl_fwd.ins_head = 1'b1;
                        ctrl_rev.wr_tail  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                REQ_REMOVE_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_removed         = back_word;
                        ctrl_rev.del_head = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                REQ_REMOVE_FRONT: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_removed         = front_word;
                        ctrl_fwd.del_head = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Front-ordered chain
    deq_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain_fwd (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl_fwd),
        .i_count (r_count),
        .i_value (i_value),
        .o_head  (front_word)
    );

    // Back-ordered chain
    deq_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain_rev (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl_rev),
        .i_count (r_count),
        .i_value (i_value),
        .o_head  (back_word)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed    <= n_removed;
            r_status     <= n_status;
            r_item_count <= COUNT_W'(n_count);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_item_count    = r_item_count;

endmodule

`default_nettype wire

[tb/sv/double_ended_queue_core_test.sv]
// Self-checking testbench for double_ended_queue_core: drives random and directed
// requests over valid/ready and checks every result word against a shadow deque.
// Depends on deq_pkg and the double_ended_queue_core RTL.
`timescale 1ns / 1ps

module double_ended_queue_core_test;
    import deq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int WALK_WORDS  = 1400;

    // One result word as the deque should report it
    typedef struct {
        logic [DATA_W-1:0]  removed;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_deq_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [1:0]                i_req_type;
    logic signed [DATA_W-1:0]  i_value;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [DATA_W-1:0]  o_removed_value;
    logic [1:0]                o_status;
    logic [COUNT_W-1:0]        o_item_count;

    // Shadow deque state
    logic [DATA_W-1:0] shadow_store [DEPTH];
    int                shadow_front;
    int                shadow_count;

    t_deq_result expected_results [$];
    int          err_count;
    int          cycles;
    int          words_sent;
    int          full_refusals;
    int          empty_refusals;
    int          max_seen_count;
    bit          quiet;

    double_ended_queue_core #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_item_count    (o_item_count)
    );

    // Clock, starting low so the first rising edge comes half a period in
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // Run length guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= quiet || ($urandom_range(0, 99) >= 13);
    end

    // Apply one request to the shadow deque and return what it should report
    function automatic t_deq_result apply_request(t_req req, logic [DATA_W-1:0] val);
        t_deq_result res;
        int          pos;
        res.removed = '0;
        res.status  = ST_OK;
        case (req)
            REQ_ADD_BACK, REQ_ADD_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (req == REQ_ADD_BACK) begin
                    pos = (shadow_front + shadow_count) % DEPTH;
                    shadow_store[pos] = val;
                    shadow_count++;
                end else begin
                    shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
                    shadow_store[shadow_front] = val;
                    shadow_count++;
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (req == REQ_REMOVE_BACK) begin
                    pos = (shadow_front + shadow_count - 1) % DEPTH;
                    res.removed = shadow_store[pos];
                    shadow_count--;
                end else begin
                    res.removed = shadow_store[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
        endcase
        res.count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    // Random word with the extremes showing up now and then
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Occasional gap on the request side
    task automatic request_gap();
        if (!quiet && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Present one request word and hold it until accepted
    task automatic send_request(t_req req, logic [DATA_W-1:0] val);
        t_deq_result res;
        request_gap();
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        res = apply_request(req, val);
        if (res.status == ST_FULL) full_refusals++;
        if (res.status == ST_EMPTY) empty_refusals++;
        if (shadow_count > max_seen_count) max_seen_count = shadow_count;
        expected_results.push_back(res);
        words_sent++;
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_deq_result exp_res;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: removed_value %0d status %0d",
                       o_removed_value, o_status);
                err_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_removed_value !== exp_res.removed) begin
                    $error("removed_value: expected %0d, got %0d",
                           $signed(exp_res.removed), o_removed_value);
                    err_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    err_count++;
                end
                if (o_item_count !== exp_res.count) begin
                    $error("item_count: expected %0d, got %0d", exp_res.count, o_item_count);
                    err_count++;
                end
            end
        end
    end

    // Removals from an empty deque at both ends
    task automatic test_empty_removals();
        send_request(REQ_REMOVE_BACK, 32'h1234_5678);
        send_request(REQ_REMOVE_FRONT, 32'hffff_ffff);
    endtask

    // Both ends with the extreme words, including front index wrap below zero
    task automatic test_ends_and_extremes();
        send_request(REQ_ADD_FRONT, 32'h8000_0000);
        send_request(REQ_ADD_BACK, 32'h7fff_ffff);
        send_request(REQ_ADD_FRONT, 32'hffff_ffff);
        send_request(REQ_ADD_BACK, 32'h0000_0000);
        send_request(REQ_ADD_FRONT, 32'haaaa_aaaa);
        send_request(REQ_ADD_BACK, 32'h5555_5555);
        send_request(REQ_REMOVE_FRONT, 32'h0);
        send_request(REQ_REMOVE_BACK, 32'h0);
        send_request(REQ_REMOVE_BACK, 32'hffff_ffff);
        send_request(REQ_REMOVE_FRONT, 32'h0);
        send_request(REQ_REMOVE_FRONT, 32'h0);
        send_request(REQ_REMOVE_BACK, 32'h0);
        send_request(REQ_REMOVE_FRONT, 32'h0);
        send_request(REQ_REMOVE_BACK, 32'h0);
    endtask

    // Fill to capacity, get refused at both ends, then drain past empty
    task automatic test_full_boundary();
        while (shadow_count < DEPTH)
            send_request($urandom_range(0, 1) ? REQ_ADD_FRONT : REQ_ADD_BACK, pick_value());
        send_request(REQ_ADD_BACK, 32'h7fff_ffff);
        send_request(REQ_ADD_FRONT, 32'h8000_0000);
        send_request(REQ_REMOVE_BACK, 32'h0);
        send_request(REQ_ADD_FRONT, pick_value());
        send_request(REQ_ADD_BACK, pick_value());
        while (shadow_count > 0)
            send_request($urandom_range(0, 1) ? REQ_REMOVE_FRONT : REQ_REMOVE_BACK, 32'h0);
        send_request(REQ_REMOVE_FRONT, 32'h0);
    endtask

    // Random walk in phases leaning toward filling, draining or neither
    task automatic test_random_walk(int n_words);
        int   add_pct;
        int   phase_left;
        int   k;
        t_req req;
        phase_left = 0;
        add_pct    = 50;
        for (k = 0; k < n_words; k++) begin
            quiet = (k >= 500 && k < 800);
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 120);
                case ($urandom_range(0, 2))
                    0:       add_pct = 85;
                    1:       add_pct = 15;
                    default: add_pct = 50;
                endcase
            end
            phase_left--;
            if ($urandom_range(0, 99) < add_pct)
                req = $urandom_range(0, 1) ? REQ_ADD_FRONT : REQ_ADD_BACK;
            else
                req = $urandom_range(0, 1) ? REQ_REMOVE_FRONT : REQ_REMOVE_BACK;
            send_request(req, pick_value());
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_req_type     <= REQ_ADD_BACK;
        i_value        <= '0;
        err_count      = 0;
        words_sent     = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        max_seen_count = 0;
        quiet          = 1'b0;
        shadow_front   = 0;
        shadow_count   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_removals();
        test_ends_and_extremes();
        test_full_boundary();
        test_random_walk(WALK_WORDS);

        // Drain outstanding results, then let the output settle
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d requests sent, %0d refused as full, %0d refused as empty,",
                 words_sent, full_refusals, empty_refusals);
        $display("deepest fill %0d of %0d, %0d mismatches", max_seen_count, DEPTH, err_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
